/* rtl/core/alc_pkg.sv */
// Shared types and constants for the adjacent label counter.
`timescale 1ns / 1ps

package alc_pkg;

  localparam int unsigned LABEL_W       = 8;
  localparam int unsigned LABEL_COUNT   = 1 << LABEL_W;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned ALC_MAX_WIDTH = 128;

  localparam logic [LABEL_W-1:0] TARGET_RST     = 8'd0;
  localparam logic [LABEL_W-1:0] BACKGROUND_RST = 8'd46;  // '.'
  localparam logic [LABEL_W-1:0] ROW_WIDTH_RST  = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET     = 2'd0,
    CFG_BACKGROUND = 2'd1,
    CFG_ROW_WIDTH  = 2'd2
  } cfg_idx_e;

  // Registered cell plus its raster context; upper label comes from the line store.
  typedef struct packed {
    logic [LABEL_W-1:0] cur_label;
    logic [LABEL_W-1:0] left_cell;
    logic               left_vld;
    logic               upper_vld;
    logic               last;
  } alc_item_t;

endpackage

/* rtl/core/alc_line_store.sv */
// Line store: one row of labels, one read/write port, registered read.
`timescale 1ns / 1ps

module alc_line_store import alc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = ALC_MAX_WIDTH,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [AW-1:0]      addr_i,
  input  logic [LABEL_W-1:0] wdata_i,
  output logic [LABEL_W-1:0] rdata_o
);

  logic [LABEL_W-1:0] mem_q [MAX_WIDTH];
  logic [LABEL_W-1:0] rdata_q;

  // Read-before-write: the read returns the label stored one row earlier.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem_q[addr_i];
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/alc_seen_tracker.sv */
// Seen-label bitmap and running distinct count for one frame.
`timescale 1ns / 1ps

module alc_seen_tracker import alc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  alc_item_t          item_i,
  input  logic [LABEL_W-1:0] upper_i,
  input  logic [LABEL_W-1:0] target_i,
  input  logic [LABEL_W-1:0] background_i,
  output logic [LABEL_W-1:0] frame_total_o
);

  logic [LABEL_COUNT-1:0] seen_q, seen_d;
  logic [LABEL_W-1:0]     total_q;

  logic               cell_is_tgt, left_is_tgt, upper_is_tgt;
  logic [LABEL_W-1:0] cand0, cand1;
  logic               cand0_vld, cand1_vld;
  logic               new0, new1;

  always_comb begin
    cell_is_tgt  = (item_i.cur_label == target_i);
    left_is_tgt  = item_i.left_vld  && (item_i.left_cell == target_i);
    upper_is_tgt = item_i.upper_vld && (upper_i == target_i);
    if (cell_is_tgt) begin
      // target cell: its left and upper neighbors are the candidates
      cand0     = item_i.left_cell;
      cand0_vld = item_i.left_vld && (item_i.left_cell != target_i)
                  && (item_i.left_cell != background_i);
      cand1     = upper_i;
      cand1_vld = item_i.upper_vld && (upper_i != target_i) && (upper_i != background_i);
    end else begin
      // non-target cell touching the target from the left or above
      cand0     = item_i.cur_label;
      cand0_vld = (item_i.cur_label != background_i) && (left_is_tgt || upper_is_tgt);
      cand1     = item_i.cur_label;
      cand1_vld = 1'b0;
    end
    new0 = cand0_vld && !seen_q[cand0];
    new1 = cand1_vld && !seen_q[cand1] && !(cand0_vld && (cand0 == cand1));
    seen_d = seen_q;
    if (new0) seen_d[cand0] = 1'b1;
    if (new1) seen_d[cand1] = 1'b1;
  end

  assign frame_total_o = total_q + LABEL_W'(new0) + LABEL_W'(new1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      total_q <= '0;
    end else if (adv_i) begin
      if (item_i.last) begin
        seen_q  <= '0;
        total_q <= '0;
      end else begin
        seen_q  <= seen_d;
        total_q <= frame_total_o;
      end
    end
  end

endmodule

/* rtl/core/adjacent_label_counter_unit.sv */
// Top level: counts distinct labels 4-adjacent to a target region of a raster grid.
`timescale 1ns / 1ps

// Adjacent label counter. Cell labels stream in raster order, one transaction
// per cell, rows of row_width cells (0 acts as 1, values above MAX_WIDTH clamp
// to MAX_WIDTH). Every label other than target_label and background_label that
// shares an edge with a target cell is counted once per frame. The transaction
// flagged frame_end closes the frame: its count passes through the input
// register and the result register to the output, and the bitmap, count and
// raster position restart.
// Throughput is one cell per cycle; the line store has one port, read and
// written in the accept cycle. The input stalls only while a frame-end
// transaction waits for the output register to drain. Config writes are always
// ready and must be issued while the block is idle.

module adjacent_label_counter_unit import alc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = ALC_MAX_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // cell input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [LABEL_W-1:0]   cell_label_i,
  input  logic                 frame_end_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LABEL_W-1:0]   distinct_count_o,
  // config writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LABEL_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW = (WW > LABEL_W) ? WW : LABEL_W;

  // ---------------- config registers ----------------
  logic [LABEL_W-1:0] target_q, background_q, row_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= TARGET_RST;
      background_q <= BACKGROUND_RST;
      row_width_q  <= ROW_WIDTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET:     target_q     <= cfg_data_i;
        CFG_BACKGROUND: background_q <= cfg_data_i;
        CFG_ROW_WIDTH:  row_width_q  <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic      s1_valid_q;
  alc_item_t s1_item_q;
  logic      s1_adv;
  logic      accept;
  logic      out_valid_q;
  logic [LABEL_W-1:0] distinct_count_q;

  // a frame-end item needs a free (or draining) output register
  assign s1_adv     = s1_valid_q && (!s1_item_q.last || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------- raster position ----------------
  logic [AW-1:0]      col_q, col_d;
  logic               first_row_q, first_row_d;
  logic [LABEL_W-1:0] left_q, left_d;
  logic [XW-1:0]      width_eff, col_next;
  logic               wrap;

  always_comb begin
    if (row_width_q == '0) begin
      width_eff = XW'(1);
    end else if (XW'(row_width_q) > XW'(MAX_WIDTH)) begin
      width_eff = XW'(MAX_WIDTH);
    end else begin
      width_eff = XW'(row_width_q);
    end
    col_next = XW'(col_q) + XW'(1);
    // >= covers a width shrunk below the current column mid-frame
    wrap     = (col_next >= width_eff);

    col_d       = wrap ? '0 : col_next[AW-1:0];
    first_row_d = first_row_q && !wrap;
    left_d      = cell_label_i;
    if (frame_end_i) begin
      col_d       = '0;
      first_row_d = 1'b1;
      left_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
      left_q      <= '0;
    end else if (accept) begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
      left_q      <= left_d;
    end
  end

  // ---------------- input register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.cur_label <= cell_label_i;
      s1_item_q.left_cell <= left_q;
      s1_item_q.left_vld  <= (col_q != '0);
      s1_item_q.upper_vld <= !first_row_q;
      s1_item_q.last      <= frame_end_i;
    end
  end

  // ---------------- line store ----------------
  logic [LABEL_W-1:0] upper_label;

  alc_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .en_i    (accept),
    .addr_i  (col_q),
    .wdata_i (cell_label_i),
    .rdata_o (upper_label)
  );

  // ---------------- seen bitmap and count ----------------
  logic [LABEL_W-1:0] frame_total;

  alc_seen_tracker u_seen_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (s1_adv),
    .item_i        (s1_item_q),
    .upper_i       (upper_label),
    .target_i      (target_q),
    .background_i  (background_q),
    .frame_total_o (frame_total)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_item_q.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_item_q.last) begin
      distinct_count_q <= frame_total;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distinct_count_o = distinct_count_q;

  // ---------------- assertions ----------------
  // input backpressure comes only from a frame-end item held for the output
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_item_q.last && out_valid_q))
    else $error("input stalled without a pending frame-end result");

  // a frame-end item that moves on always lands a result
  a_result_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_item_q.last) |=> out_valid_q)
    else $error("frame end processed but no result presented");

  // past the first row, only a frame end brings the first-row flag back
  a_first_row_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !frame_end_i && !first_row_q) |=> !first_row_q)
    else $error("first-row flag set again mid-frame");

endmodule
